@@ rtl/sitda_pkg.sv @@
package sitda_pkg;

	// ascii codes used in the text
	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;

	// field width limit, sign included
	localparam logic [4:0] MAX_WIDTH = 5'd20;

	// character and digit counts fit this width
	localparam int CNT_W = 5;

	// status from the converter to the sequencer
	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] ndig;
	} conv_status_t;

endpackage

@@ rtl/sitda_in_if.sv @@
interface sitda_in_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] value;
	logic        [4:0]  min_width;

	modport source (output valid, output value, output min_width, input ready);
	modport sink (input valid, input value, input min_width, output ready);
endinterface

@@ rtl/sitda_out_if.sv @@
interface sitda_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       last;

	modport source (output valid, output char_out, output last, input ready);
	modport sink (input valid, input char_out, input last, output ready);
endinterface

@@ rtl/sitda_dabble.sv @@
module sitda_dabble #(
	parameter int VALUE_BITS = 64,
	parameter int NDIG = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [VALUE_BITS-1:0]         mag,
	output logic [NDIG-1:0][3:0]          bcd,
	output sitda_pkg::conv_status_t       status
);

	localparam int CW = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0] shreg_q;
	logic [NDIG-1:0][3:0]  bcd_q;
	logic [NDIG-1:0][3:0]  adj;
	logic [4*NDIG-1:0]     adj_flat;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  fin_q;
	logic [sitda_pkg::CNT_W-1:0] ndig;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	assign adj_flat = adj;

	// one magnitude bit into the digit register per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= mag;
			bcd_q   <= '0;
		end else if (busy_q) begin
			shreg_q <= {shreg_q[VALUE_BITS-2:0], 1'b0};
			bcd_q   <= {adj_flat[4*NDIG-2:0], shreg_q[VALUE_BITS-1]};
		end
	end

	// significant digit count, at least one
	always_comb begin
		ndig = sitda_pkg::CNT_W'(1);
		for (int i = 1; i < NDIG; i++) begin
			if (bcd_q[i] != 4'd0) ndig = sitda_pkg::CNT_W'(i + 1);
		end
	end

	assign bcd         = bcd_q;
	assign status.done = fin_q;
	assign status.ndig = ndig;

	a_fin_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> $past(busy_q))
		else $error("conversion finished without running");
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("bit counter empty while busy");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("conversion restarted while busy");

endmodule

@@ rtl/signed_int_to_decimal_ascii_top.sv @@
// an accepted value goes through the bit-serial binary to decimal converter, one magnitude
// bit per cycle, then the sequencer emits its text, one character per cycle while the output
// is taken, 1 to 20 characters; a new value is taken only once the last character of the
// previous text has been loaded into the output register
// reset: asynchronous, clears the sequencer, output valid and the converter's control state, no other state
module signed_int_to_decimal_ascii_top #(
	parameter int VALUE_BITS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	sitda_in_if.sink     in_item,
	sitda_out_if.source  out_item
);

	localparam int NDIG = ((VALUE_BITS * 1233) >> 12) + 1;
	localparam int IW   = $clog2(NDIG);
	localparam int CW   = sitda_pkg::CNT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]            st_q;
	logic                  neg_q;
	logic                  first_q;
	logic [CW-1:0]         body_q;
	logic [CW-1:0]         rem_q;
	logic [CW-1:0]         ndig_q;
	logic                  out_valid_q;
	logic [7:0]            out_char_q;
	logic                  out_last_q;

	logic                  accept;
	logic                  load;
	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;
	logic                  neg;
	logic [4:0]            width;
	logic [CW-1:0]         body;
	logic [CW-1:0]         pos;
	logic [CW-1:0]         total;
	logic [7:0]            next_char;
	logic [NDIG-1:0][3:0]  bcd;
	sitda_pkg::conv_status_t status;

	// input decode: sign, magnitude, clamped width
	assign raw    = in_item.value[VALUE_BITS-1:0];
	assign neg    = raw[VALUE_BITS-1];
	assign mag    = neg ? (~raw + VALUE_BITS'(1)) : raw;
	assign width  = (in_item.min_width > sitda_pkg::MAX_WIDTH) ? sitda_pkg::MAX_WIDTH
		: in_item.min_width;
	assign body   = (neg && width != 5'd0) ? width - 5'd1 : (neg ? 5'd0 : width);

	assign in_item.ready = (st_q == ST_IDLE);
	assign accept        = in_item.valid && in_item.ready;

	sitda_dabble #(
		.VALUE_BITS (VALUE_BITS),
		.NDIG       (NDIG)
	) u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (mag),
		.bcd    (bcd),
		.status (status)
	);

	// text length once the digit count is known
	assign total = ((body_q > status.ndig) ? body_q : status.ndig) + CW'(neg_q);

	// character at the current position, counted from the right
	assign pos  = rem_q - CW'(1);
	assign load = (st_q == ST_EMIT) && (!out_valid_q || out_item.ready);
	always_comb begin
		if (pos < ndig_q) begin
			next_char = sitda_pkg::CHAR_ZERO | {4'd0, bcd[pos[IW-1:0]]};
		end else if (neg_q && first_q) begin
			next_char = sitda_pkg::CHAR_MINUS;
		end else begin
			next_char = sitda_pkg::CHAR_ZERO;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
			first_q     <= 1'b0;
			rem_q       <= '0;
		end else begin
			// output register: filled on load, emptied when taken
			if (load) out_valid_q <= 1'b1;
			else if (out_item.ready) out_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (accept) st_q <= ST_CONV;
				end
				ST_CONV: begin
					if (status.done) begin
						st_q    <= ST_EMIT;
						rem_q   <= total;
						first_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (load) begin
						first_q     <= 1'b0;
						rem_q       <= pos;
						if (rem_q == CW'(1)) st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// item payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q  <= neg;
			body_q <= body;
		end
		if (status.done) ndig_q <= status.ndig;
		if (load) begin
			out_char_q <= next_char;
			out_last_q <= (rem_q == CW'(1));
		end
	end

	assign out_item.valid    = out_valid_q;
	assign out_item.char_out = out_char_q;
	assign out_item.last     = out_last_q;

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_EMIT |-> rem_q != '0)
		else $error("emitting with no characters left");
	a_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		status.done |-> st_q == ST_CONV)
		else $error("conversion result outside conversion state");
	a_accept_conv: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> st_q == ST_CONV)
		else $error("accepted item did not start a conversion");
	a_ndig_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_EMIT |-> ndig_q <= CW'(NDIG) && ndig_q != '0)
		else $error("digit count out of range");

endmodule

@@ sim/sitda_text_checker.sv @@
`timescale 1ns / 1ps

module sitda_text_checker (
	input  logic clk,
	input  logic arst_n,
	sitda_in_if  in_mon,
	sitda_out_if out_mon,
	output int   fail_count,
	output int   pending,
	output int   chars_seen
);

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	// characters still owed by the block, oldest first
	text_char_t expected_chars[$];
	int         mismatches = 0;
	int         seen = 0;

	// decimal text of one value: sign, zero padding, digits msd first
	function automatic void predict_text(input logic [63:0] raw, input logic [4:0] min_w);
		logic [63:0] mag;
		logic [63:0] rem;
		logic [7:0]  digits [0:19];
		logic        neg;
		int          nd;
		int          w;
		int          body;
		int          pad;
		int          lead;
		int          total;
		text_char_t  c;
		neg = raw[63];
		// unsigned negation so the most negative value converts exactly
		mag = neg ? (64'd0 - raw) : raw;
		nd = 0;
		do begin
			rem = mag % 64'd10;
			digits[nd] = sitda_pkg::CHAR_ZERO + rem[7:0];
			nd++;
			mag = mag / 64'd10;
		end while (mag != 64'd0);
		// widths past the limit are clamped, the sign takes one place
		w = (min_w > sitda_pkg::MAX_WIDTH) ? sitda_pkg::MAX_WIDTH : min_w;
		body = neg ? ((w > 0) ? w - 1 : 0) : w;
		pad = (body > nd) ? body - nd : 0;
		lead = (neg ? 1 : 0) + pad;
		total = lead + nd;
		for (int k = 0; k < total; k++) begin
			if (neg && k == 0)
				c.ch = sitda_pkg::CHAR_MINUS;
			else if (k < lead)
				c.ch = sitda_pkg::CHAR_ZERO;
			else
				c.ch = digits[total - 1 - k];
			c.last = (k == total - 1);
			expected_chars = {expected_chars, c};
		end
	endfunction

	// watch both channels, predict on input and compare on output
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (in_mon.valid && in_mon.ready)
				predict_text(in_mon.value, in_mon.min_width);
			if (out_mon.valid && out_mon.ready) begin
				seen++;
				if (expected_chars.size() == 0) begin
					if (mismatches < 10)
						$display("[%0t] unexpected item: char %0d last %0b, nothing pending",
							$time, out_mon.char_out, out_mon.last);
					mismatches++;
				end else begin
					want = expected_chars.pop_front();
					if (out_mon.char_out !== want.ch || out_mon.last !== want.last) begin
						if (mismatches < 10)
							$display("[%0t] mismatch: expected char %0d last %0b, got char %0d last %0b",
								$time, want.ch, want.last, out_mon.char_out, out_mon.last);
						mismatches++;
					end
				end
			end
		end
		fail_count <= mismatches;
		pending    <= expected_chars.size();
		chars_seen <= seen;
	end

endmodule

@@ sim/tb_signed_int_to_decimal_ascii_top.sv @@
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii_top;

	localparam int N_RANDOM = 190;
	localparam logic signed [63:0] VAL_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;

	typedef enum logic [1:0] {RX_FREE, RX_BUSY, RX_TOGGLE, RX_SLOW} rx_mode_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     rx_ready = 1'b0;
	logic     rx_toggle = 1'b0;
	rx_mode_t rx_mode = RX_FREE;
	int       rx_hold = 0;
	int       fail_count;
	int       pending;
	int       chars_seen;
	int       items_sent = 0;
	int       burst_left = 0;

	sitda_in_if  in_item();
	sitda_out_if out_item();

	signed_int_to_decimal_ascii_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.out_item (out_item)
	);

	sitda_text_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_item),
		.out_mon    (out_item),
		.fail_count (fail_count),
		.pending    (pending),
		.chars_seen (chars_seen)
	);

	always #5 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// receiver: stall pattern that changes mode every so often
	assign out_item.ready = rx_ready;

	always @(posedge clk) begin
		if (!arst_n) begin
			rx_ready <= 1'b0;
		end else begin
			if (rx_hold == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_hold <= $urandom_range(20, 200);
			end else begin
				rx_hold <= rx_hold - 1;
			end
			rx_toggle <= ~rx_toggle;
			case (rx_mode)
				RX_FREE:   rx_ready <= 1'b1;
				RX_BUSY:   rx_ready <= ($urandom_range(0, 3) != 0);
				RX_TOGGLE: rx_ready <= rx_toggle;
				default:   rx_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// offer one item and hold it until taken, then maybe end the burst
	task automatic send_text(input logic signed [63:0] v, input logic [4:0] w);
		int gap;
		in_item.valid     <= 1'b1;
		in_item.value     <= v;
		in_item.min_width <= w;
		do @(posedge clk); while (!in_item.ready);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 9);
			if ($urandom_range(0, 9) < 3)
				gap = 0;
			else if ($urandom_range(0, 9) == 0)
				gap = $urandom_range(20, 100);
			else
				gap = $urandom_range(1, 6);
			if (gap > 0) begin
				in_item.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop sending until every owed character has come out
	task automatic wait_drained();
		in_item.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// stimulus
	initial begin
		logic [63:0] v;
		logic [63:0] p;
		logic [4:0]  w;
		int          kind;
		in_item.valid     <= 1'b0;
		in_item.value     <= '0;
		in_item.min_width <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero, extremes, clamping, padding and short widths
		send_text(64'sd0, 5'd0);
		send_text(64'sd0, 5'd20);
		send_text(64'sd5, 5'd31);
		send_text(64'sd7, 5'd21);
		send_text(VAL_MAX, 5'd0);
		send_text(VAL_MAX, 5'd20);
		send_text(VAL_MIN, 5'd0);
		send_text(VAL_MIN, 5'd20);
		send_text(VAL_MIN, 5'd31);
		send_text(VAL_MIN + 64'sd1, 5'd0);
		send_text(-64'sd1, 5'd0);
		send_text(-64'sd1, 5'd1);
		send_text(-64'sd1, 5'd2);
		send_text(-64'sd1, 5'd20);
		send_text(64'sd12345, 5'd3);
		send_text(-64'sd12345, 5'd6);
		send_text(64'sd9, 5'd1);
		send_text(64'sd10, 5'd2);
		send_text(-64'sd10, 5'd4);
		send_text(64'sd999999999999999999, 5'd19);
		send_text(64'sd1000000000000000000, 5'd0);
		send_text(-64'sd9, 5'd0);
		send_text(64'sd42, 5'd5);
		wait_drained();

		// random values of every magnitude, mostly in-range widths
		for (int i = 0; i < N_RANDOM; i++) begin
			kind = $urandom_range(0, 9);
			v = {$urandom, $urandom};
			if (kind == 3 || kind == 4) begin
				v = v >> $urandom_range(0, 63);
			end else if (kind == 5) begin
				p = 64'd1;
				repeat ($urandom_range(0, 18)) p = p * 64'd10;
				v = p - 64'd1 + $urandom_range(0, 2);
			end else if (kind == 6) begin
				v = $urandom_range(0, 200);
				v = v - 64'd100;
			end else if (kind >= 7) begin
				case ($urandom_range(0, 4))
					0:       v = VAL_MAX;
					1:       v = VAL_MIN;
					2:       v = VAL_MIN + 64'sd1;
					3:       v = '1;
					default: v = '0;
				endcase
			end
			if (kind >= 3 && kind <= 5 && $urandom_range(0, 1) == 1)
				v = -v;
			if ($urandom_range(0, 9) < 7)
				w = $urandom_range(0, 20);
			else
				w = $urandom_range(0, 31);
			send_text(v, w);
			if (i == N_RANDOM / 2)
				wait_drained();
		end

		wait_drained();
		repeat (100) @(posedge clk);
		$display("%0d values converted (zero, both extremes, widths 0..31), %0d characters checked",
			items_sent, chars_seen);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/sitda_pkg.sv
rtl/sitda_in_if.sv
rtl/sitda_out_if.sv
rtl/sitda_dabble.sv
rtl/signed_int_to_decimal_ascii_top.sv
sim/sitda_text_checker.sv
sim/tb_signed_int_to_decimal_ascii_top.sv
